/* hdl/bbhs_pkg.sv */
// ----------------------------------------------------------------------------
// bbhs_pkg: shared definitions for the block bounding box statistics unit
// Default sizes, command codes, register map and controller state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bbhs_pkg;

	// Default sizes handed to the top level parameters.
	localparam int NUM_BLOCKS_DEF  = 256;
	localparam int COORD_BITS_DEF  = 16;

	// Fixed field widths.
	localparam int ID_W   = 8;
	localparam int POS_W  = 15;
	localparam int CNT_W  = 16;
	localparam int HSUM_W = 32;
	localparam int OUT_W  = 16;

	// Request commands carried in the stream side-band.
	localparam logic [1:0] MODE_ACCOUNT = 2'd0;
	localparam logic [1:0] MODE_QUERY   = 2'd1;
	localparam logic [1:0] MODE_CLEAR   = 2'd2;

	// Averaging modes.
	localparam logic AVG_ROOTS  = 1'b0;
	localparam logic AVG_LEGACY = 1'b1;

	// Register word index of avg_mode.
	localparam logic REG_AVG_MODE = 1'b0;

	// Controller states.
	typedef enum logic [4:0] {
		ST_INIT = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_CALC = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage

`default_nettype wire

/* hdl/block_bbox_height_stats.sv */
// ----------------------------------------------------------------------------
// block_bbox_height_stats: per-block bounding box and height statistics
// Keeps one table entry per block label and reports box, counts and the
// average component height for every request.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                         Contents
// s_*       in         s_tvalid/s_tready/s_tdata/s_tuser  component or command
// m_*       out        m_tvalid/m_tready/m_tdata/m_tuser  entry report
// APB       in/out     psel/penable/pwrite/paddr/...    avg_mode register
//
// One request at a time: the entry memory is read when the request is taken,
// the entry is updated and written back, then a bit-serial divide follows when
// the entry is in use and the average needs it, before the report is handed over.
// After reset a clearing pass sweeps the memory; no request is taken meanwhile.
// The result register lets the next request in while the previous report waits
// on m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module block_bbox_height_stats #(
	parameter int NUM_BLOCKS = bbhs_pkg::NUM_BLOCKS_DEF,
	parameter int COORD_BITS = bbhs_pkg::COORD_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Request stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// block_id[7:0], x_pos[22:8], y_pos[37:23], comp_width[52:38],
	// comp_height[67:53], is_dust[68], is_letter[69], zero[71:70]
	input  wire logic [71:0]  s_tdata,
	// mode[1:0]
	input  wire logic [1:0]   s_tuser,
	// Report stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// out_block_id[7:0], box_left[23:8], box_top[39:24], box_right[55:40],
	// box_bottom[71:56], root_count[87:72], letter_count[103:88],
	// dust_count[119:104], avg_height[135:120]
	output logic [135:0]      m_tdata,
	// entry_valid[0]
	output logic [0:0]        m_tuser,
	// Configuration port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int IW      = $clog2(NUM_BLOCKS);
	localparam int CB      = COORD_BITS;
	localparam int CNT_W   = bbhs_pkg::CNT_W;
	localparam int HSUM_W  = bbhs_pkg::HSUM_W;
	localparam int POS_W   = bbhs_pkg::POS_W;
	localparam int ID_W    = bbhs_pkg::ID_W;
	localparam int BOX_LO  = 1;
	localparam int CNT_LO  = BOX_LO + 4 * CB;
	localparam int HS_LO   = CNT_LO + 3 * CNT_W;
	localparam int MW      = HS_LO + HSUM_W;
	localparam int CW      = 25;
	localparam logic [CW-1:0] CMAX = CW'((64'd1 << CB) - 64'd1);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BLOCKS - 1);

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic avg_mode_q;

	assign pready = 1'b1;

	// avg_mode is written at the access phase of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_mode_q <= bbhs_pkg::AVG_ROOTS;
		end else if (psel && penable && pwrite && pready &&
			     paddr[2] == bbhs_pkg::REG_AVG_MODE) begin
			avg_mode_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == bbhs_pkg::REG_AVG_MODE) ? {31'd0, avg_mode_q} : 32'd0;

	// ------------------------------------------------------------------
	// Request fields
	// ------------------------------------------------------------------
	logic [ID_W-1:0]   s_block_id;
	logic [IW+ID_W-1:0] s_id_ext;
	logic [IW-1:0]     s_index;
	logic              accept;

	assign s_block_id = s_tdata[7:0];
	assign s_id_ext   = (IW + ID_W)'(s_block_id);
	assign s_index    = s_id_ext[IW-1:0];

	bbhs_pkg::state_t state_q;

	assign s_tready = (state_q == bbhs_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	logic [1:0]        mode_q;
	logic [ID_W-1:0]   id_q;
	logic [IW-1:0]     index_q;
	logic              in_range_q;
	logic [POS_W-1:0]  x_q, y_q, w_q, h_q;
	logic              dust_q, letter_q;

	// Capture the request as it is taken.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q     <= s_tuser;
			id_q       <= s_block_id;
			index_q    <= s_index;
			in_range_q <= (32'(s_block_id) < 32'(NUM_BLOCKS));
			x_q        <= s_tdata[22:8];
			y_q        <= s_tdata[37:23];
			w_q        <= (s_tdata[52:38] == '0) ? POS_W'(1) : s_tdata[52:38];
			h_q        <= (s_tdata[67:53] == '0) ? POS_W'(1) : s_tdata[67:53];
			dust_q     <= s_tdata[68];
			letter_q   <= s_tdata[69];
		end
	end

	// ------------------------------------------------------------------
	// Entry memory: used mark, box, counts and height sum in one word
	// ------------------------------------------------------------------
	logic [MW-1:0] mem [NUM_BLOCKS];
	logic [MW-1:0] rd_q;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [MW-1:0] mem_wdata;
	logic [IW-1:0] clr_q;

	// Synchronous write port and registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			rd_q <= mem[s_index];
		end
	end

	// ------------------------------------------------------------------
	// Update of the addressed entry
	// ------------------------------------------------------------------
	logic              old_used;
	logic [CB-1:0]     old_l, old_t, old_r, old_b;
	logic [CNT_W-1:0]  old_root, old_let, old_dust;
	logic [HSUM_W-1:0] old_hs;
	logic [CW-1:0]     r_full, b_full;
	logic [CB-1:0]     c_l, c_t, c_r, c_b;
	logic [HSUM_W:0]   hs_sum;
	logic              new_used;
	logic [CB-1:0]     new_l, new_t, new_r, new_b;
	logic [CNT_W-1:0]  new_root, new_let, new_dust;
	logic [HSUM_W-1:0] new_hs;
	logic              upd_we;

	assign old_used = in_range_q && rd_q[0];
	assign old_l    = rd_q[BOX_LO        +: CB];
	assign old_t    = rd_q[BOX_LO + CB   +: CB];
	assign old_r    = rd_q[BOX_LO + 2*CB +: CB];
	assign old_b    = rd_q[BOX_LO + 3*CB +: CB];
	assign old_root = rd_q[CNT_LO           +: CNT_W];
	assign old_let  = rd_q[CNT_LO + CNT_W   +: CNT_W];
	assign old_dust = rd_q[CNT_LO + 2*CNT_W +: CNT_W];
	assign old_hs   = rd_q[HS_LO +: HSUM_W];

	// Component edges, saturated to the coordinate range.
	assign r_full = CW'(x_q) + CW'(w_q) - CW'(1);
	assign b_full = CW'(y_q) + CW'(h_q) - CW'(1);
	assign c_l = (CW'(x_q) > CMAX) ? CB'(CMAX) : CB'(x_q);
	assign c_t = (CW'(y_q) > CMAX) ? CB'(CMAX) : CB'(y_q);
	assign c_r = (r_full > CMAX) ? CB'(CMAX) : CB'(r_full);
	assign c_b = (b_full > CMAX) ? CB'(CMAX) : CB'(b_full);
	assign hs_sum = (HSUM_W + 1)'(old_hs) + (HSUM_W + 1)'(h_q);

	// New contents of the entry; a query leaves it as it was.
	always_comb begin
		new_used = old_used;
		new_l    = old_l;
		new_t    = old_t;
		new_r    = old_r;
		new_b    = old_b;
		new_root = old_root;
		new_let  = old_let;
		new_dust = old_dust;
		new_hs   = old_hs;
		upd_we   = 1'b0;
		if (in_range_q && mode_q == bbhs_pkg::MODE_ACCOUNT) begin
			upd_we   = 1'b1;
			new_used = 1'b1;
			if (!old_used) begin
				// First component sets the box and starts the counts.
				new_l    = c_l;
				new_t    = c_t;
				new_r    = c_r;
				new_b    = c_b;
				new_root = CNT_W'(1);
				new_let  = CNT_W'(letter_q);
				new_dust = '0;
				new_hs   = HSUM_W'(h_q);
			end else begin
				new_l    = (c_l < old_l) ? c_l : old_l;
				new_t    = (c_t < old_t) ? c_t : old_t;
				new_r    = (c_r > old_r) ? c_r : old_r;
				new_b    = (c_b > old_b) ? c_b : old_b;
				new_root = (old_root == CNT_MAX) ? old_root : old_root + CNT_W'(1);
				if (letter_q && old_let != CNT_MAX) begin
					new_let = old_let + CNT_W'(1);
				end
				if (dust_q && old_dust != CNT_MAX) begin
					new_dust = old_dust + CNT_W'(1);
				end
				new_hs = hs_sum[HSUM_W] ? '1 : hs_sum[HSUM_W-1:0];
			end
		end else if (in_range_q && mode_q == bbhs_pkg::MODE_CLEAR) begin
			upd_we   = 1'b1;
			new_used = 1'b0;
		end
	end

	// Memory write: the clearing sweep after reset, else the write-back.
	always_comb begin
		if (state_q == bbhs_pkg::ST_INIT) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = (state_q == bbhs_pkg::ST_CALC) && upd_we;
			mem_waddr = index_q;
			mem_wdata = {new_hs, new_dust, new_let, new_root,
				     new_b, new_r, new_t, new_l, new_used};
		end
	end

	// ------------------------------------------------------------------
	// Report registers, divider and controller
	// ------------------------------------------------------------------
	logic              rv_q;
	logic [CB-1:0]     rl_q, rt_q, rr_q, rb_q;
	logic [CNT_W-1:0]  rroot_q, rlet_q, rdust_q;
	logic [CNT_W-1:0]  avg_q;
	logic [HSUM_W-1:0] num_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [4:0]        div_cnt_q;
	logic              skip_div;
	logic [CNT_W-1:0]  divisor;
	logic [CNT_W:0]    trial;
	logic              qbit;
	logic [HSUM_W-1:0] quot;
	logic [CNT_W-1:0]  avg_sat;
	logic              m_tvalid_q;
	logic [135:0]      m_tdata_q;
	logic              m_tuser_q;
	logic              out_free;

	// Divisor choice and the cases with a fixed average of one.
	always_comb begin
		divisor  = new_root;
		skip_div = !(in_range_q && new_used);
		if (avg_mode_q == bbhs_pkg::AVG_LEGACY && new_root != new_dust) begin
			if (new_dust > new_root) begin
				skip_div = 1'b1;
			end
			divisor = new_root - new_dust;
		end
	end

	// One quotient bit per cycle, restoring form.
	assign trial = {rem_q, num_q[HSUM_W-1]};
	assign qbit  = (trial >= {1'b0, dvs_q});
	assign quot  = {num_q[HSUM_W-2:0], qbit};
	assign avg_sat = (quot == '0) ? CNT_W'(1) :
			 ((|quot[HSUM_W-1:CNT_W]) ? CNT_MAX : quot[CNT_W-1:0]);

	assign out_free = !m_tvalid_q || m_tready;

	// Payload registers of the request under work.
	always_ff @(posedge clk) begin
		if (state_q == bbhs_pkg::ST_CALC) begin
			rv_q    <= in_range_q && new_used;
			rl_q    <= new_l;
			rt_q    <= new_t;
			rr_q    <= new_r;
			rb_q    <= new_b;
			rroot_q <= new_root;
			rlet_q  <= new_let;
			rdust_q <= new_dust;
			num_q   <= new_hs;
			rem_q   <= '0;
			dvs_q   <= divisor;
			avg_q   <= CNT_W'(1);
		end else if (state_q == bbhs_pkg::ST_DIV) begin
			num_q <= quot;
			rem_q <= qbit ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
			if (div_cnt_q == '1) begin
				avg_q <= avg_sat;
			end
		end
	end

	// Controller: clearing sweep, read, update, divide, hand-over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bbhs_pkg::ST_INIT;
			clr_q     <= '0;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				bbhs_pkg::ST_INIT: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == LAST_IDX) begin
						state_q <= bbhs_pkg::ST_IDLE;
					end
				end
				bbhs_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= bbhs_pkg::ST_CALC;
					end
				end
				bbhs_pkg::ST_CALC: begin
					div_cnt_q <= '0;
					state_q   <= skip_div ? bbhs_pkg::ST_DONE : bbhs_pkg::ST_DIV;
				end
				bbhs_pkg::ST_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == '1) begin
						state_q <= bbhs_pkg::ST_DONE;
					end
				end
				bbhs_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= bbhs_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= bbhs_pkg::ST_INIT;
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == bbhs_pkg::ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output register payload; an empty entry reports zeros and an average of one.
	always_ff @(posedge clk) begin
		if (state_q == bbhs_pkg::ST_DONE && out_free) begin
			m_tuser_q <= rv_q;
			if (rv_q) begin
				m_tdata_q <= {avg_q, rdust_q, rlet_q, rroot_q,
					      16'(rb_q), 16'(rr_q), 16'(rt_q), 16'(rl_q), id_q};
			end else begin
				m_tdata_q <= {CNT_W'(1), 112'd0, id_q};
			end
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_accept_to_calc: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == bbhs_pkg::ST_CALC)
		else $error("accepted request did not move to the update cycle");

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bbhs_pkg::ST_INIT |-> !s_tready)
		else $error("request taken during the clearing sweep");

	a_valid_has_roots: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[87:72] != 16'd0)
		else $error("entry in use reported with no roots");

	a_avg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[135:120] != 16'd0)
		else $error("average height of zero reported");

	a_empty_report: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[119:8] == '0 && m_tdata[135:120] == 16'd1)
		else $error("empty entry reported with non-zero statistics");

endmodule

`default_nettype wire

/* tb/bbhs_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bbhs_checker: scoreboard for the block bounding box statistics unit
// Watches the request, report and register channels, keeps its own copy of
// the entry table, works out the report that each request must produce and
// compares every report field by field with the oldest one outstanding.
// ----------------------------------------------------------------------------

module bbhs_checker
	import bbhs_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	input  wire logic          s_tready,
	// block_id, x_pos, y_pos, comp_width, comp_height, is_dust, is_letter, zero
	input  wire logic [71:0]   s_tdata,
	// mode
	input  wire logic [1:0]    s_tuser,
	input  wire logic          m_tvalid,
	input  wire logic          m_tready,
	// out_block_id, box_left, box_top, box_right, box_bottom, root_count,
	// letter_count, dust_count, avg_height
	input  wire logic [135:0]  m_tdata,
	// entry_valid
	input  wire logic [0:0]    m_tuser,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic          pready,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output int                 pending,
	output int                 fail_count
);

	localparam int COORD_MAX = (1 << COORD_BITS_DEF) - 1;
	localparam logic [CNT_W-1:0] CNT_SAT = '1;

	// One component request as it lies in s_tdata, lowest field last.
	typedef struct packed {
		logic [1:0]       pad;
		logic             is_letter;
		logic             is_dust;
		logic [POS_W-1:0] comp_height;
		logic [POS_W-1:0] comp_width;
		logic [POS_W-1:0] y_pos;
		logic [POS_W-1:0] x_pos;
		logic [ID_W-1:0]  block_id;
	} component_t;

	// One report: m_tuser on top of m_tdata.
	typedef struct packed {
		logic             entry_valid;
		logic [OUT_W-1:0] avg_height;
		logic [OUT_W-1:0] dust_count;
		logic [OUT_W-1:0] letter_count;
		logic [OUT_W-1:0] root_count;
		logic [OUT_W-1:0] box_bottom;
		logic [OUT_W-1:0] box_right;
		logic [OUT_W-1:0] box_top;
		logic [OUT_W-1:0] box_left;
		logic [ID_W-1:0]  out_block_id;
	} report_t;

	// Shadow of the averaging register and of the entry table.
	logic              avg_sel;
	logic              in_use     [NUM_BLOCKS_DEF];
	logic [OUT_W-1:0]  left_col   [NUM_BLOCKS_DEF];
	logic [OUT_W-1:0]  top_row    [NUM_BLOCKS_DEF];
	logic [OUT_W-1:0]  right_col  [NUM_BLOCKS_DEF];
	logic [OUT_W-1:0]  bottom_row [NUM_BLOCKS_DEF];
	logic [CNT_W-1:0]  roots      [NUM_BLOCKS_DEF];
	logic [CNT_W-1:0]  letters    [NUM_BLOCKS_DEF];
	logic [CNT_W-1:0]  dusts      [NUM_BLOCKS_DEF];
	logic [HSUM_W-1:0] height_sum [NUM_BLOCKS_DEF];

	report_t expected_reports[$];

	function automatic logic [OUT_W-1:0] clamp_coord(input int v);
		return (v > COORD_MAX) ? COORD_MAX[OUT_W-1:0] : v[OUT_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c == CNT_SAT) ? c : c + 1'b1;
	endfunction

	// Height sum over roots, or over non-dust roots in the legacy mode.
	function automatic logic [OUT_W-1:0] mean_height(input logic [HSUM_W-1:0] sum,
			input logic [CNT_W-1:0] n_roots, input logic [CNT_W-1:0] n_dust);
		logic [HSUM_W-1:0] divisor;
		logic [HSUM_W-1:0] quotient;
		if (n_roots == 0)
			return OUT_W'(1);
		divisor = HSUM_W'(n_roots);
		if (avg_sel == AVG_LEGACY && n_roots != n_dust) begin
			if (n_dust > n_roots)
				return OUT_W'(1);
			divisor = HSUM_W'(n_roots - n_dust);
		end
		quotient = sum / divisor;
		if (quotient < 1)
			quotient = HSUM_W'(1);
		if (quotient > CNT_SAT)
			quotient = HSUM_W'(CNT_SAT);
		return quotient[OUT_W-1:0];
	endfunction

	// Apply one request to the shadow table and queue the report it yields.
	task automatic predict_report(input logic [1:0] mode, input component_t c);
		int               id;
		int               w;
		int               h;
		logic [OUT_W-1:0] l;
		logic [OUT_W-1:0] t;
		logic [OUT_W-1:0] r;
		logic [OUT_W-1:0] b;
		logic [HSUM_W:0]  sum;
		report_t          rep;
		id = c.block_id;
		w = (c.comp_width == 0) ? 1 : c.comp_width;
		h = (c.comp_height == 0) ? 1 : c.comp_height;
		if (id < NUM_BLOCKS_DEF) begin
			if (mode == MODE_ACCOUNT) begin
				l = clamp_coord(c.x_pos);
				t = clamp_coord(c.y_pos);
				r = clamp_coord(int'(c.x_pos) + w - 1);
				b = clamp_coord(int'(c.y_pos) + h - 1);
				if (!in_use[id]) begin
					// The first component opens the box and never counts as dust.
					in_use[id] = 1'b1;
					left_col[id] = l;
					top_row[id] = t;
					right_col[id] = r;
					bottom_row[id] = b;
					roots[id] = '0;
					letters[id] = '0;
					dusts[id] = '0;
					height_sum[id] = h;
				end else begin
					sum = height_sum[id] + h;
					height_sum[id] = sum[HSUM_W] ? '1 : sum[HSUM_W-1:0];
					if (l < left_col[id])
						left_col[id] = l;
					if (t < top_row[id])
						top_row[id] = t;
					if (r > right_col[id])
						right_col[id] = r;
					if (b > bottom_row[id])
						bottom_row[id] = b;
					if (c.is_dust)
						dusts[id] = bump(dusts[id]);
				end
				roots[id] = bump(roots[id]);
				if (c.is_letter)
					letters[id] = bump(letters[id]);
			end else if (mode == MODE_CLEAR) begin
				in_use[id] = 1'b0;
			end
		end

		rep = '0;
		rep.out_block_id = c.block_id;
		rep.avg_height = OUT_W'(1);
		if (id < NUM_BLOCKS_DEF && in_use[id]) begin
			rep.entry_valid = 1'b1;
			rep.box_left = left_col[id];
			rep.box_top = top_row[id];
			rep.box_right = right_col[id];
			rep.box_bottom = bottom_row[id];
			rep.root_count = roots[id];
			rep.letter_count = letters[id];
			rep.dust_count = dusts[id];
			rep.avg_height = mean_height(height_sum[id], roots[id], dusts[id]);
		end
		expected_reports.push_back(rep);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic compare_report(input report_t want, input report_t got);
		check_field("out_block_id", want.out_block_id, got.out_block_id);
		check_field("entry_valid", want.entry_valid, got.entry_valid);
		check_field("box_left", want.box_left, got.box_left);
		check_field("box_top", want.box_top, got.box_top);
		check_field("box_right", want.box_right, got.box_right);
		check_field("box_bottom", want.box_bottom, got.box_bottom);
		check_field("root_count", want.root_count, got.root_count);
		check_field("letter_count", want.letter_count, got.letter_count);
		check_field("dust_count", want.dust_count, got.dust_count);
		check_field("avg_height", want.avg_height, got.avg_height);
	endtask

	// Reports are checked before new requests are queued in the same cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_sel = AVG_ROOTS;
			for (int i = 0; i < NUM_BLOCKS_DEF; i++)
				in_use[i] = 1'b0;
			expected_reports.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_reports.size() == 0) begin
					$error("report for block %0d arrived with no request outstanding",
						m_tdata[ID_W-1:0]);
					fail_count++;
				end else begin
					compare_report(expected_reports.pop_front(), {m_tuser[0], m_tdata});
				end
			end
			if (psel && penable && pwrite && pready && paddr == {REG_AVG_MODE, 2'b00})
				avg_sel = pwdata[0];
			if (s_tvalid && s_tready)
				predict_report(s_tuser, component_t'(s_tdata));
			pending <= expected_reports.size();
		end
	end

endmodule

/* tb/tb_block_bbox_height_stats.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_bbox_height_stats: testbench for the block statistics unit
// Drives component, query and clear requests with random gaps and report
// back-pressure, switches the averaging mode between phases, and leaves all
// checking to the scoreboard instantiated beside the block.
// ----------------------------------------------------------------------------

module tb_block_bbox_height_stats;
	import bbhs_pkg::*;

	// Mode code the block does not define; it must report like a query.
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int TAIL_CYCLES = 40;

	logic          clk      = 1'b0;
	logic          arst_n   = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [71:0]   s_tdata  = '0;
	logic [1:0]    s_tuser  = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [135:0]  m_tdata;
	logic [0:0]    m_tuser;
	logic          psel     = 1'b0;
	logic          penable  = 1'b0;
	logic          pwrite   = 1'b0;
	logic [2:0]    paddr    = '0;
	logic [31:0]   pwdata   = '0;
	logic [31:0]   prdata;
	logic          pready;
	int            pending;
	int            fail_count;
	bit            sender_steady = 1'b0;

	always #5 clk = ~clk;

	block_bbox_height_stats dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	bbhs_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// Send one request after a random gap and wait until it is taken.
	task automatic send_request(input logic [1:0] mode, input logic [7:0] id,
			input logic [14:0] x, input logic [14:0] y, input logic [14:0] w,
			input logic [14:0] h, input logic dust, input logic letter);
		int gap;
		if ($urandom_range(0, 99) < 3)
			sender_steady = !sender_steady;
		gap = sender_steady ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {2'b00, letter, dust, h, w, y, x, id};
		do @(posedge clk); while (!s_tready);
	endtask

	// Wait until every report is back and the block has gone quiet.
	task automatic wait_drain;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_avg_mode(input logic value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_AVG_MODE, 2'b00};
		pwdata <= {31'($urandom_range(0, 32'h7FFF_FFFF)), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Random requests, mostly piling components onto a handful of entries.
	task automatic random_phase(input int count);
		logic [7:0]  pool [6];
		logic [1:0]  mode;
		logic [7:0]  id;
		logic [14:0] x;
		logic [14:0] y;
		logic [14:0] w;
		logic [14:0] h;
		int          pick;
		foreach (pool[i])
			pool[i] = 8'($urandom_range(0, 255));
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 62)
				mode = MODE_ACCOUNT;
			else if (pick < 87)
				mode = MODE_QUERY;
			else if (pick < 96)
				mode = MODE_CLEAR;
			else
				mode = MODE_SPARE;
			id = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 5)]
				: 8'($urandom_range(0, 255));
			x = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
				: 15'($urandom_range(0, 1023));
			y = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
				: 15'($urandom_range(0, 1023));
			w = ($urandom_range(0, 9) == 0) ? 15'($urandom_range(0, 32767))
				: 15'($urandom_range(0, 60));
			h = ($urandom_range(0, 9) == 0) ? 15'($urandom_range(0, 32767))
				: 15'($urandom_range(0, 60));
			send_request(mode, id, x, y, w, h, $urandom_range(0, 9) < 3,
				1'($urandom_range(0, 1)));
		end
	endtask

	// Report side: random stalls, with stretches of steady acceptance.
	initial begin : report_sink
		int stall;
		bit steady;
		steady = 1'b0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 99) < 4)
				steady = !steady;
			stall = steady ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_avg_mode(AVG_ROOTS);

		// Directed part: empty entry, size extremes, spare mode, clear, dust.
		send_request(MODE_QUERY, 8'd0, 15'd0, 15'd0, 15'd0, 15'd0, 1'b0, 1'b0);
		send_request(MODE_ACCOUNT, 8'd0, 15'd0, 15'd0, 15'd0, 15'd0, 1'b1, 1'b1);
		send_request(MODE_ACCOUNT, 8'd0, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF,
			1'b1, 1'b0);
		send_request(MODE_ACCOUNT, 8'd255, 15'd100, 15'd200, 15'd5, 15'd7, 1'b0, 1'b1);
		send_request(MODE_QUERY, 8'd255, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF,
			1'b1, 1'b1);
		send_request(MODE_SPARE, 8'd0, 15'd3, 15'd3, 15'd3, 15'd3, 1'b0, 1'b0);
		send_request(MODE_CLEAR, 8'd0, 15'd0, 15'd0, 15'd1, 15'd1, 1'b0, 1'b0);
		send_request(MODE_QUERY, 8'd0, 15'd0, 15'd0, 15'd1, 15'd1, 1'b0, 1'b0);
		send_request(MODE_ACCOUNT, 8'd0, 15'd40, 15'd50, 15'd2, 15'd9, 1'b0, 1'b0);
		send_request(MODE_CLEAR, 8'd200, 15'd0, 15'd0, 15'd1, 15'd1, 1'b0, 1'b0);
		send_request(MODE_ACCOUNT, 8'd7, 15'd10, 15'd10, 15'd4, 15'd10, 1'b0, 1'b1);
		send_request(MODE_ACCOUNT, 8'd7, 15'd5, 15'd30, 15'd1, 15'd20, 1'b1, 1'b0);
		send_request(MODE_ACCOUNT, 8'd7, 15'd12, 15'd2, 15'd8, 15'd30, 1'b1, 1'b1);
		send_request(MODE_ACCOUNT, 8'd7, 15'd0, 15'd0, 15'd0, 15'd0, 1'b1, 1'b0);
		send_request(MODE_QUERY, 8'd7, 15'd0, 15'd0, 15'd0, 15'd0, 1'b0, 1'b0);
		wait_drain();

		// Legacy averaging over the same entries.
		write_avg_mode(AVG_LEGACY);
		send_request(MODE_QUERY, 8'd7, 15'd0, 15'd0, 15'd0, 15'd0, 1'b0, 1'b0);
		send_request(MODE_QUERY, 8'd0, 15'd0, 15'd0, 15'd0, 15'd0, 1'b0, 1'b0);
		send_request(MODE_QUERY, 8'd255, 15'd0, 15'd0, 15'd0, 15'd0, 1'b0, 1'b0);
		send_request(MODE_QUERY, 8'd1, 15'd0, 15'd0, 15'd0, 15'd0, 1'b0, 1'b0);
		random_phase(325);
		wait_drain();

		write_avg_mode(AVG_ROOTS);
		random_phase(325);
		wait_drain();

		write_avg_mode(AVG_LEGACY);
		random_phase(325);
		wait_drain();

		write_avg_mode(AVG_ROOTS);
		random_phase(325);
		wait_drain();

		if (fail_count == 0 && pending == 0)
			$display("[block_bbox_height_stats] OK");
		else
			$display("[block_bbox_height_stats] ERROR");
		$finish;
	end

	// Run limit, well beyond the slowest legal run.
	initial begin : watchdog
		#5_000_000;
		$display("[block_bbox_height_stats] ERROR");
		$finish;
	end

endmodule
